// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the interval sampler core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/isbam_pkg.sv =====
// ---------------------------------------------------------------------------
// isbam_pkg
// Types, constants and register indexes of the interval sampler core.
// ---------------------------------------------------------------------------
package isbam_pkg;

   // Sampling and averaging
   localparam int MAX_SAMPLES = 16;
   localparam int SAMPLE_BITS = 12;
   localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W       = $clog2(MAX_SAMPLES * ((1 << SAMPLE_BITS) - 1) + 1);
   localparam int TIME_W      = 32;
   localparam int VALUE_W     = 32;
   localparam int CFG_W       = 16;

   // Shared serial divider
   localparam int DIV_W       = 42;
   localparam int DEN_W       = 16;
   localparam int STEP_W      = $clog2(DIV_W + 1);
   localparam int MAP_MAG_W   = 32;

   localparam logic signed [10:0] PER_MILLE = 11'sd1000;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_INTERVAL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AVERAGE_COUNT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAPPING_ENABLE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_LOW       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_HIGH      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_LOW      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_HIGH     = 3'd6;

   typedef struct packed {
      logic [TIME_W-1:0]      tick_time;
      logic [SAMPLE_BITS-1:0] adc_sample;
   } isbam_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic signed [VALUE_W-1:0] per_mille;
      logic                      sample_taken;
      logic                      block_done;
      logic                      divide_error;
   } isbam_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_VAL_SEL,
      ST_MAP_MUL,
      ST_MAP_GO,
      ST_MAP_WAIT,
      ST_MAP_ADD,
      ST_PM_MUL,
      ST_PM_GO,
      ST_PM_WAIT,
      ST_OUTPUT
   } isbam_state_type;

   typedef enum logic [1:0] {
      DIV_MEAN,
      DIV_MAP,
      DIV_PM
   } isbam_div_sel_type;

   typedef struct packed {
      logic              capture;
      logic              div_start;
      isbam_div_sel_type div_sel;
      logic              mean_store;
      logic              val_load;
      logic              map_mul;
      logic              map_add;
      logic              pm_mul;
      logic              out_load;
   } isbam_cmd_type;

   typedef struct packed {
      logic block_done;
      logic map_go;
      logic pm_go;
      logic div_done;
      logic out_free;
   } isbam_status_type;

endpackage

// ===== rtl/core/isbam_div.sv =====
// ---------------------------------------------------------------------------
// isbam_div
// Unsigned restoring divider, one quotient bit per cycle. The dividend
// arrives left-aligned; after the requested number of steps the quotient
// sits in the low bits of the work register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module isbam_div import isbam_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [STEP_W-1:0] steps,
   output logic              done,
   output logic [DIV_W-1:0]  quot
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [DIV_W-1:0]  work_ff, work_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;

   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    trial_diff;
   logic              fits;

   assign trial      = {rem_ff, work_ff[DIV_W-1]};
   assign fits       = (trial >= {1'b0, den_ff});
   assign trial_diff = trial - {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      steps_in = steps_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         steps_in = steps;
         work_in  = num;
         rem_in   = '0;
         den_in   = den;
      end else if (busy_ff) begin
         work_in = {work_ff[DIV_W-2:0], fits};
         rem_in  = fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in  = cnt_ff + STEP_W'(1);
         if (cnt_ff == steps_ff - STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff <= steps_in;
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
   end

   assign done = done_ff;
   assign quot = work_ff;

   `ASSERT_IMPLIES(a_no_restart_while_busy, clock, reset, start, !busy_ff)
   `ASSERT_IMPLIES(a_done_follows_busy, clock, reset, done_ff, $past(busy_ff))

endmodule

// ===== rtl/core/isbam_datapath.sv =====
// ---------------------------------------------------------------------------
// isbam_datapath
// Configuration registers, sampling state, mapping and per-mille arithmetic
// around the shared serial divider, and the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module isbam_datapath import isbam_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  isbam_req_type         req_data,
   input  isbam_cmd_type         cmd,
   output isbam_status_type      status,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output isbam_rsp_type         rsp_data
);

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
   localparam int                     SUM_X_W    = DIV_W + 2;

   // Saturate a wide signed value to the result width.
   function automatic logic signed [VALUE_W-1:0] sat_value(
      input logic signed [SUM_X_W-1:0] x
   );
      if (x[SUM_X_W-1:VALUE_W-1] == {(SUM_X_W-VALUE_W+1){x[SUM_X_W-1]}}) begin
         return x[VALUE_W-1:0];
      end else if (x[SUM_X_W-1]) begin
         return {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         return {1'b0, {(VALUE_W-1){1'b1}}};
      end
   endfunction

   // Configuration
   logic [CFG_W-1:0]        interval_ff, interval_in;
   logic [COUNT_W-1:0]      avg_count_ff, avg_count_in;
   logic                    map_en_ff, map_en_in;
   logic signed [CFG_W-1:0] in_low_ff, in_low_in;
   logic signed [CFG_W-1:0] in_high_ff, in_high_in;
   logic signed [CFG_W-1:0] out_low_ff, out_low_in;
   logic signed [CFG_W-1:0] out_high_ff, out_high_in;

   // Sampling state
   logic [TIME_W-1:0]      last_time_ff, last_time_in;
   logic [COUNT_W-1:0]     index_ff, index_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic                   taken_ff, taken_in;
   logic                   done_ff, done_in;
   logic [SUM_W-1:0]       mean_num_ff, mean_num_in;
   logic [COUNT_W-1:0]     mean_den_ff, mean_den_in;

   // Arithmetic
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic signed [DIV_W-1:0]   prod_ff, prod_in;
   logic                      neg_ff, neg_in;

   // Result register
   logic                      rsp_valid_ff, rsp_valid_in;
   isbam_rsp_type             rsp_data_ff, rsp_data_in;

   logic [TIME_W-1:0]         tick_delta;
   logic                      take;
   logic [COUNT_W-1:0]        count_eff;
   logic [SUM_W-1:0]          sum_add;
   logic [COUNT_W-1:0]        idx_add;
   logic                      block_full;

   logic signed [CFG_W:0]     map_den;
   logic                      map_den_zero;
   logic [CFG_W:0]            map_den_abs;
   logic signed [CFG_W:0]     out_high_x;
   logic [CFG_W:0]            out_high_abs;
   logic signed [CFG_W+1:0]   map_a;
   logic signed [CFG_W:0]     map_b;
   logic signed [CFG_W*2+2:0] map_prod;
   logic signed [DIV_W-1:0]   pm_prod;
   logic [DIV_W-1:0]          prod_mag;

   logic [DIV_W-1:0]          div_num;
   logic [DEN_W-1:0]          div_den;
   logic [STEP_W-1:0]         div_steps;
   logic                      div_neg;
   logic                      div_done;
   logic [DIV_W-1:0]          div_quot;
   logic signed [DIV_W:0]     quot_signed;
   logic signed [SUM_X_W-1:0] quot_x;
   logic signed [SUM_X_W-1:0] map_sum;
   logic signed [VALUE_W-1:0] pm_value;
   logic                      div_err;

   // ---------------- configuration writes ----------------
   always_comb begin
      interval_in  = interval_ff;
      avg_count_in = avg_count_ff;
      map_en_in    = map_en_ff;
      in_low_in    = in_low_ff;
      in_high_in   = in_high_ff;
      out_low_in   = out_low_ff;
      out_high_in  = out_high_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SAMPLE_INTERVAL: interval_in  = csr_wdata[CFG_W-1:0];
            CSR_AVERAGE_COUNT:   avg_count_in = csr_wdata[COUNT_W-1:0];
            CSR_MAPPING_ENABLE:  map_en_in    = csr_wdata[0];
            CSR_INPUT_LOW:       in_low_in    = $signed(csr_wdata[CFG_W-1:0]);
            CSR_INPUT_HIGH:      in_high_in   = $signed(csr_wdata[CFG_W-1:0]);
            CSR_OUTPUT_LOW:      out_low_in   = $signed(csr_wdata[CFG_W-1:0]);
            CSR_OUTPUT_HIGH:     out_high_in  = $signed(csr_wdata[CFG_W-1:0]);
            default: ;
         endcase
      end
   end

   // ---------------- sampling ----------------
   assign tick_delta = req_data.tick_time - last_time_ff;
   assign take       = (tick_delta > {{(TIME_W-CFG_W){1'b0}}, interval_ff});
   assign sum_add    = sum_ff + {{(SUM_W-SAMPLE_BITS){1'b0}}, req_data.adc_sample};
   assign idx_add    = index_ff + COUNT_W'(1);
   assign block_full = (idx_add >= count_eff);

   always_comb begin
      if (avg_count_ff == '0) begin
         count_eff = COUNT_W'(1);
      end else if (avg_count_ff > COUNT_W'(MAX_SAMPLES)) begin
         count_eff = COUNT_W'(MAX_SAMPLES);
      end else begin
         count_eff = avg_count_ff;
      end
   end

   always_comb begin
      last_time_in = last_time_ff;
      index_in     = index_ff;
      sum_in       = sum_ff;
      taken_in     = taken_ff;
      done_in      = done_ff;
      mean_num_in  = mean_num_ff;
      mean_den_in  = mean_den_ff;
      if (cmd.capture) begin
         taken_in = take;
         done_in  = take && block_full;
         if (take) begin
            last_time_in = req_data.tick_time;
            if (block_full) begin
               // close the block: hand sum and count to the divider
               index_in    = '0;
               sum_in      = '0;
               mean_num_in = sum_add;
               mean_den_in = idx_add;
            end else begin
               index_in = idx_add;
               sum_in   = sum_add;
            end
         end
      end
   end

   always_comb begin
      avg_in = avg_ff;
      if (cmd.mean_store) begin
         if (div_quot > {{(DIV_W-SAMPLE_BITS){1'b0}}, SAMPLE_MAX}) begin
            avg_in = SAMPLE_MAX;
         end else begin
            avg_in = div_quot[SAMPLE_BITS-1:0];
         end
      end
   end

   // ---------------- mapping and per-mille ----------------
   assign map_den      = $signed({in_high_ff[CFG_W-1], in_high_ff})
                       - $signed({in_low_ff[CFG_W-1], in_low_ff});
   assign map_den_zero = (map_den == '0);
   assign map_den_abs  = map_den[CFG_W] ? -map_den : map_den;
   assign out_high_x   = $signed({out_high_ff[CFG_W-1], out_high_ff});
   assign out_high_abs = out_high_x[CFG_W] ? -out_high_x : out_high_x;

   assign map_a    = $signed({{(CFG_W+2-SAMPLE_BITS){1'b0}}, avg_ff})
                   - $signed({{2{in_low_ff[CFG_W-1]}}, in_low_ff});
   assign map_b    = $signed({out_high_ff[CFG_W-1], out_high_ff})
                   - $signed({out_low_ff[CFG_W-1], out_low_ff});
   assign map_prod = $signed({{(CFG_W+1){map_a[CFG_W+1]}}, map_a})
                   * $signed({{(CFG_W+2){map_b[CFG_W]}}, map_b});
   assign pm_prod  = $signed({{(DIV_W-VALUE_W){val_ff[VALUE_W-1]}}, val_ff})
                   * $signed({{(DIV_W-11){PER_MILLE[10]}}, PER_MILLE});
   assign prod_mag = prod_ff[DIV_W-1] ? -prod_ff : prod_ff;

   always_comb begin
      prod_in = prod_ff;
      if (cmd.map_mul) begin
         prod_in = {{(DIV_W-(CFG_W*2+3)){map_prod[CFG_W*2+2]}}, map_prod};
      end else if (cmd.pm_mul) begin
         prod_in = pm_prod;
      end
   end

   // Divider operands: left-align the dividend to its step count.
   always_comb begin
      case (cmd.div_sel)
         DIV_MAP: begin
            div_num   = {prod_mag[MAP_MAG_W-1:0], {(DIV_W-MAP_MAG_W){1'b0}}};
            div_den   = map_den_abs[DEN_W-1:0];
            div_steps = STEP_W'(MAP_MAG_W);
            div_neg   = prod_ff[DIV_W-1] ^ map_den[CFG_W];
         end
         DIV_PM: begin
            div_num   = prod_mag;
            div_den   = out_high_abs[DEN_W-1:0];
            div_steps = STEP_W'(DIV_W);
            div_neg   = prod_ff[DIV_W-1] ^ out_high_ff[CFG_W-1];
         end
         default: begin
            div_num   = {mean_num_ff, {(DIV_W-SUM_W){1'b0}}};
            div_den   = {{(DEN_W-COUNT_W){1'b0}}, mean_den_ff};
            div_steps = STEP_W'(SUM_W);
            div_neg   = 1'b0;
         end
      endcase
   end

   assign neg_in = cmd.div_start ? div_neg : neg_ff;

   isbam_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .steps (div_steps),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign quot_signed = neg_ff ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
   assign quot_x      = $signed({quot_signed[DIV_W], quot_signed});
   assign map_sum     = quot_x
                      + $signed({{(SUM_X_W-CFG_W){out_low_ff[CFG_W-1]}}, out_low_ff});

   always_comb begin
      val_in = val_ff;
      if (cmd.val_load) begin
         // mapping with a zero span reads as zero; a live mapping overwrites later
         val_in = map_en_ff ? '0 : $signed({{(VALUE_W-SAMPLE_BITS){1'b0}}, avg_ff});
      end else if (cmd.map_add) begin
         val_in = sat_value(map_sum);
      end
   end

   assign pm_value = status.pm_go ? sat_value(quot_x) : '0;
   assign div_err  = (map_en_ff && map_den_zero) || (out_high_ff == '0);

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.out_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.value        = val_ff;
         rsp_data_in.per_mille    = pm_value;
         rsp_data_in.sample_taken = taken_ff;
         rsp_data_in.block_done   = done_ff;
         rsp_data_in.divide_error = div_err;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      status.block_done = done_ff;
      status.map_go     = map_en_ff && !map_den_zero;
      status.pm_go      = (out_high_ff != '0);
      status.div_done   = div_done;
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= '0;
         avg_count_ff <= COUNT_W'(1);
         map_en_ff    <= 1'b0;
         in_low_ff    <= '0;
         in_high_ff   <= 16'sd4096;
         out_low_ff   <= '0;
         out_high_ff  <= '0;
         last_time_ff <= '0;
         index_ff     <= '0;
         sum_ff       <= '0;
         avg_ff       <= '0;
         taken_ff     <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         interval_ff  <= interval_in;
         avg_count_ff <= avg_count_in;
         map_en_ff    <= map_en_in;
         in_low_ff    <= in_low_in;
         in_high_ff   <= in_high_in;
         out_low_ff   <= out_low_in;
         out_high_ff  <= out_high_in;
         last_time_ff <= last_time_in;
         index_ff     <= index_in;
         sum_ff       <= sum_in;
         avg_ff       <= avg_in;
         taken_ff     <= taken_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mean_num_ff <= mean_num_in;
      mean_den_ff <= mean_den_in;
      val_ff      <= val_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ASSERT_IMPLIES(a_out_load_free, clock, reset, cmd.out_load, !rsp_valid_ff || !rsp_stall)
   `ASSERT_IMPLIES(a_index_in_range, clock, reset, 1'b1, index_ff < COUNT_W'(MAX_SAMPLES))

endmodule

// ===== rtl/core/isbam_ctrl.sv =====
// ---------------------------------------------------------------------------
// isbam_ctrl
// Sequencer: takes one transaction, steps the datapath through mean,
// mapping and per-mille as each applies, then hands the result to the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module isbam_ctrl import isbam_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  isbam_status_type status,
   output isbam_cmd_type    cmd
);

   isbam_state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_DECIDE;
         ST_DECIDE:    state_in = status.block_done ? ST_MEAN_GO : ST_VAL_SEL;
         ST_MEAN_GO:   state_in = ST_MEAN_WAIT;
         ST_MEAN_WAIT: if (status.div_done) state_in = ST_VAL_SEL;
         ST_VAL_SEL: begin
            if (status.map_go) begin
               state_in = ST_MAP_MUL;
            end else if (status.pm_go) begin
               state_in = ST_PM_MUL;
            end else begin
               state_in = ST_OUTPUT;
            end
         end
         ST_MAP_MUL:   state_in = ST_MAP_GO;
         ST_MAP_GO:    state_in = ST_MAP_WAIT;
         ST_MAP_WAIT:  if (status.div_done) state_in = ST_MAP_ADD;
         ST_MAP_ADD:   state_in = status.pm_go ? ST_PM_MUL : ST_OUTPUT;
         ST_PM_MUL:    state_in = ST_PM_GO;
         ST_PM_GO:     state_in = ST_PM_WAIT;
         ST_PM_WAIT:   if (status.div_done) state_in = ST_OUTPUT;
         ST_OUTPUT:    if (status.out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd         = '0;
      cmd.div_sel = DIV_MEAN;
      req_stall   = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE:      cmd.capture = req_valid;
         ST_MEAN_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_MEAN;
         end
         ST_MEAN_WAIT: cmd.mean_store = status.div_done;
         ST_VAL_SEL:   cmd.val_load = 1'b1;
         ST_MAP_MUL:   cmd.map_mul = 1'b1;
         ST_MAP_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_MAP;
         end
         ST_MAP_ADD: begin
            cmd.map_add = 1'b1;
            cmd.div_sel = DIV_MAP;
         end
         ST_PM_MUL:    cmd.pm_mul = 1'b1;
         ST_PM_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_PM;
         end
         ST_OUTPUT:    cmd.out_load = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_capture_leaves_idle, clock, reset, cmd.capture, state_ff != ST_IDLE)

endmodule

// ===== rtl/core/interval_sampler_block_average_map_core.sv =====
// ---------------------------------------------------------------------------
// interval_sampler_block_average_map_core
// Interval sampler with block averaging, linear range mapping and per-mille.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one transaction per tick carrying tick_time and adc_sample,
//   taken when req_valid is high and req_stall low. req_stall is high while
//   a tick is being worked on.
//   rsp channel: exactly one result per tick (value, per_mille and the
//   sample_taken, block_done, divide_error flags), held in an output
//   register until taken with rsp_valid high and rsp_stall low.
//   csr port: csr_write with csr_index and csr_wdata writes one register;
//   write only while no tick is in flight.
// Timing: all divisions share one restoring divider that retires one
//   quotient bit per cycle. A tick runs a mean division when it closes an
//   averaging block, a mapping division when mapping is enabled with a
//   nonzero input span and a per-mille division with a nonzero output_high;
//   the next tick is taken only after the result has been loaded.
//   The result appears in the same cycle as the next tick can be taken.
// Stall: a waiting result does not block the next tick; only when the next
//   result is ready while the previous one still waits does the core hold.
// Reset: clears the sampling state and loads the register defaults.
// ---------------------------------------------------------------------------
module interval_sampler_block_average_map_core import isbam_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  isbam_req_type         req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output isbam_rsp_type         rsp_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   isbam_cmd_type    cmd;
   isbam_status_type status;

   isbam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   isbam_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
